// File: rtl/core/ictw_pkg.sv
// Idle connection timing wheel: shared types and constants.
// Used by the channel interfaces, the wheel engine and the top level.
package ictw_pkg;

    localparam int CMD_W     = 2;
    localparam int CONN_W    = 6;
    localparam int KIND_W    = 2;
    localparam int TIMEOUT_W = 6;
    localparam int COUNT_W   = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    localparam int DEF_MAX_CONNECTIONS = 64;
    localparam int DEF_MAX_SLOTS       = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_OPEN    = 2'd0,
        CMD_REFRESH = 2'd1,
        CMD_CLOSE   = 2'd2,
        CMD_TICK    = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 2'd0,
        KIND_CLOSED  = 2'd1,
        KIND_EXPIRED = 2'd2
    } t_kind;

    typedef struct packed {
        logic                 we;
        logic [TIMEOUT_W-1:0] wdata;
        logic [TIMEOUT_W-1:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [CONN_W-1:0] conn;
        logic              last;
    } t_evt;

endpackage

// File: rtl/core/ictw_ifs.sv
// Idle connection timing wheel: command request and event response channels.
// Depends on ictw_pkg for field widths.
interface ictw_req_if;
    logic                        valid;
    logic                        ready;
    logic [ictw_pkg::CMD_W-1:0]  command;
    logic [ictw_pkg::CONN_W-1:0] connection;

    modport source (output valid, output command, output connection, input ready);
    modport sink   (input valid, input command, input connection, output ready);
endinterface

interface ictw_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ictw_pkg::KIND_W-1:0] event_kind;
    logic [ictw_pkg::CONN_W-1:0] event_connection;
    logic                        last;

    modport source (output valid, output event_kind, output event_connection, output last,
                    input ready);
    modport sink   (input valid, input event_kind, input event_connection, input last,
                    output ready);
endinterface

// File: rtl/core/idle_connection_timing_wheel_top.sv
// Idle connection timing wheel top level: timeout register, event output register.
// Depends on ictw_pkg, ictw_req_if, ictw_rsp_if and ictw_engine.
//
//   channel   dir  handshake       payload
//   i_req     in   valid/ready     command, connection
//   o_rsp     out  valid/ready     event_kind, event_connection, last
//   i_cfg_*   in   write enable    wheel_timeout (6 bits)
//
// Open, refresh, close and a tick with timeout zero take a request accept
// plus one read-modify-write of the slot and count memories.
// An enabled tick takes a slot row read, then a walk of every connection through the
// count memory port, then the final event.
// Reset is synchronous; memory contents are qualified by per-entry valid bits cleared
// at reset, so there is no clearing pass. A held output stalls the engine only when it
// has another event to issue; a new request is taken while an event waits.
module idle_connection_timing_wheel_top #(
    parameter int MAX_CONNECTIONS = ictw_pkg::DEF_MAX_CONNECTIONS,
    parameter int MAX_SLOTS       = ictw_pkg::DEF_MAX_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ictw_req_if.sink                         i_req,
    ictw_rsp_if.source                       o_rsp,
    input  logic                             i_cfg_we,
    input  logic [ictw_pkg::TIMEOUT_W-1:0]   i_cfg_wdata
);
    import ictw_pkg::*;

    logic [TIMEOUT_W-1:0] r_timeout;
    logic                 r_out_valid;
    t_kind                r_kind;
    logic [CONN_W-1:0]    r_conn;
    logic                 r_last;

    t_cfg cfg;
    t_evt evt;
    logic out_free;

    assign cfg.we      = i_cfg_we;
    assign cfg.wdata   = i_cfg_wdata;
    assign cfg.timeout = r_timeout;
    assign out_free    = !r_out_valid || o_rsp.ready;

    ictw_engine #(
        .MAX_CONNECTIONS (MAX_CONNECTIONS),
        .MAX_SLOTS       (MAX_SLOTS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg      (cfg),
        .i_out_free (out_free),
        .o_evt      (evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (evt.valid) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt.valid) begin
            r_kind <= evt.kind;
            r_conn <= evt.conn;
            r_last <= evt.last;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.event_kind       = r_kind;
    assign o_rsp.event_connection = r_conn;
    assign o_rsp.last             = r_last;

endmodule

// File: rtl/core/ictw_engine.sv
// Idle connection timing wheel engine: slot and count memories, live mask, sequencer.
// Depends on ictw_pkg and ictw_req_if; events go to the output register in the top level.
module ictw_engine #(
    parameter int MAX_CONNECTIONS = ictw_pkg::DEF_MAX_CONNECTIONS,
    parameter int MAX_SLOTS       = ictw_pkg::DEF_MAX_SLOTS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ictw_req_if.sink       i_req,
    input  ictw_pkg::t_cfg i_cfg,
    input  logic           i_out_free,
    output ictw_pkg::t_evt o_evt
);
    import ictw_pkg::*;

    localparam int CW = $clog2(MAX_CONNECTIONS);
    localparam int SW = $clog2(MAX_SLOTS);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_CONNECTIONS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_UPD   = 5'b00010,
        S_TLOAD = 5'b00100,
        S_TSCAN = 5'b01000,
        S_TDONE = 5'b10000
    } t_state;

    function automatic logic [SW-1:0] last_of(input logic [TIMEOUT_W-1:0] t);
        logic [SW-1:0] res;
        if (32'(t) > 32'(MAX_SLOTS - 1)) begin
            res = SW'(MAX_SLOTS - 1);
        end else begin
            res = SW'(t);
        end
        return res;
    endfunction

    t_state                     r_state, n_state;
    t_cmd                       r_cmd, n_cmd;
    logic [CONN_W-1:0]          r_conn, n_conn;
    logic                       r_conn_ok, n_conn_ok;
    logic [MAX_CONNECTIONS-1:0] r_live, n_live;
    logic [SW-1:0]              r_exp, n_exp;
    logic [MAX_SLOTS-1:0]       r_svalid, n_svalid;
    logic [MAX_CONNECTIONS-1:0] r_cvalid, n_cvalid;
    logic [MAX_CONNECTIONS-1:0] r_row, n_row;
    logic [CW-1:0]              r_idx, n_idx;
    logic                       r_hold_v, n_hold_v;
    logic [CW-1:0]              r_hold, n_hold;

    logic [MAX_CONNECTIONS-1:0] r_slot_mem [MAX_SLOTS];
    logic [MAX_CONNECTIONS-1:0] r_row_q;
    logic [SW-1:0]              r_saddr;
    logic [COUNT_W-1:0]         r_cnt_mem [MAX_CONNECTIONS];
    logic [COUNT_W-1:0]         r_cnt_q;
    logic [CW-1:0]              r_caddr;

    logic                       s_we, s_re;
    logic [SW-1:0]              s_raddr;
    logic                       c_we, c_re;
    logic [CW-1:0]              c_waddr, c_raddr;
    logic [COUNT_W-1:0]         c_wdata;

    logic [SW-1:0]              last_slot, last_new, safe_slot, e_next;
    logic [MAX_CONNECTIONS-1:0] row_cur, row_upd;
    logic [COUNT_W-1:0]         cnt_cur, cnt_inc;
    logic [CW-1:0]              ci;
    logic                       ena, in_ok, hit, expire, stall;

    assign i_req.ready = (r_state == S_IDLE);

    assign ena       = (i_cfg.timeout != '0);
    assign last_slot = last_of(i_cfg.timeout);
    assign last_new  = last_of(i_cfg.wdata);
    assign safe_slot = (r_exp == '0) ? last_slot : SW'(r_exp - 1'b1);
    assign e_next    = (r_exp >= last_slot) ? '0 : SW'(r_exp + 1'b1);
    assign in_ok     = (32'(i_req.connection) < 32'(MAX_CONNECTIONS));
    assign ci        = r_conn[CW-1:0];

    assign row_cur = r_svalid[r_saddr] ? r_row_q : '0;
    assign cnt_cur = r_cvalid[r_caddr] ? r_cnt_q : '0;
    assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : COUNT_W'(cnt_cur + 1'b1);

    always_comb begin
        row_upd     = row_cur;
        row_upd[ci] = 1'b1;
    end

    assign hit    = r_row[r_idx] && r_live[r_idx];
    assign expire = hit && (cnt_cur <= COUNT_W'(1));
    assign stall  = expire && r_hold_v && !i_out_free;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_conn    = r_conn;
        n_conn_ok = r_conn_ok;
        n_live    = r_live;
        n_exp     = r_exp;
        n_svalid  = r_svalid;
        n_cvalid  = r_cvalid;
        n_row     = r_row;
        n_idx     = r_idx;
        n_hold_v  = r_hold_v;
        n_hold    = r_hold;
        s_we      = 1'b0;
        s_re      = 1'b0;
        s_raddr   = safe_slot;
        c_we      = 1'b0;
        c_re      = 1'b0;
        c_waddr   = ci;
        c_raddr   = CW'(i_req.connection);
        c_wdata   = cnt_inc;
        o_evt       = '0;
        o_evt.kind  = KIND_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd     = t_cmd'(i_req.command);
                    n_conn    = i_req.connection;
                    n_conn_ok = in_ok;
                    s_re      = 1'b1;
                    if ((t_cmd'(i_req.command) == CMD_TICK) && ena) begin
                        n_exp   = e_next;
                        s_raddr = e_next;
                        n_state = S_TLOAD;
                    end else begin
                        c_re    = 1'b1;
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                if (i_out_free) begin
                    o_evt.valid = 1'b1;
                    o_evt.last  = 1'b1;
                    n_state     = S_IDLE;
                    if (r_conn_ok) begin
                        unique case (r_cmd) inside
                            CMD_OPEN, CMD_REFRESH: begin
                                if (r_cmd == CMD_OPEN) begin
                                    n_live[ci] = 1'b1;
                                end
                                if (ena && !row_cur[ci]) begin
                                    s_we               = 1'b1;
                                    n_svalid[r_saddr]  = 1'b1;
                                    c_we               = 1'b1;
                                    n_cvalid[ci]       = 1'b1;
                                end
                            end
                            CMD_CLOSE: begin
                                n_live[ci]   = 1'b0;
                                n_cvalid[ci] = 1'b0;
                                if (r_live[ci]) begin
                                    o_evt.kind = KIND_CLOSED;
                                    o_evt.conn = r_conn;
                                end
                            end
                            CMD_TICK: begin
                            end
                        endcase
                    end
                end
            end
            S_TLOAD: begin
                n_row             = row_cur;
                n_svalid[r_saddr] = 1'b0;
                c_re              = 1'b1;
                c_raddr           = '0;
                n_idx             = '0;
                n_hold_v          = 1'b0;
                n_state           = S_TSCAN;
            end
            S_TSCAN: begin
                if (!stall) begin
                    c_waddr = r_idx;
                    if (hit && !expire) begin
                        c_we    = 1'b1;
                        c_wdata = COUNT_W'(cnt_cur - 1'b1);
                    end
                    if (expire) begin
                        n_live[r_idx]   = 1'b0;
                        n_cvalid[r_idx] = 1'b0;
                        if (r_hold_v) begin
                            o_evt.valid = 1'b1;
                            o_evt.kind  = KIND_EXPIRED;
                            o_evt.conn  = CONN_W'(r_hold);
                        end
                        n_hold_v = 1'b1;
                        n_hold   = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_TDONE;
                    end else begin
                        n_idx   = CW'(r_idx + 1'b1);
                        c_re    = 1'b1;
                        c_raddr = CW'(r_idx + 1'b1);
                    end
                end
            end
            S_TDONE: begin
                if (i_out_free) begin
                    o_evt.valid = 1'b1;
                    o_evt.last  = 1'b1;
                    if (r_hold_v) begin
                        o_evt.kind = KIND_EXPIRED;
                        o_evt.conn = CONN_W'(r_hold);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // timeout change: pull the expiring slot back into the smaller wheel
        if (i_cfg.we && (r_exp > last_new)) begin
            n_exp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_live   <= '0;
            r_exp    <= '0;
            r_svalid <= '0;
            r_cvalid <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_live   <= n_live;
            r_exp    <= n_exp;
            r_svalid <= n_svalid;
            r_cvalid <= n_cvalid;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_conn    <= n_conn;
        r_conn_ok <= n_conn_ok;
        r_row     <= n_row;
        r_idx     <= n_idx;
        r_hold    <= n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_slot_mem[r_saddr] <= row_upd;
        end
        if (s_re) begin
            r_row_q <= r_slot_mem[s_raddr];
            r_saddr <= s_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_cnt_mem[c_waddr] <= c_wdata;
        end
        if (c_re) begin
            r_cnt_q <= r_cnt_mem[c_raddr];
            r_caddr <= c_raddr;
        end
    end

    a_evt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.valid |-> i_out_free)
        else $error("event issued while output register busy");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp <= last_slot)
        else $error("expiring slot outside wheel");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req.valid) |=> (r_state != S_IDLE))
        else $error("accepted request not processed");

    a_expired_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && o_evt.kind == KIND_EXPIRED) |-> (r_state == S_TSCAN || r_state == S_TDONE))
        else $error("expiry reported outside tick walk");

endmodule

// File: tb/tb_idle_connection_timing_wheel_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for idle_connection_timing_wheel_top: a scoreboard class predicts
// every event from the accepted requests. Depends on ictw_pkg, ictw_req_if, ictw_rsp_if.
module tb_idle_connection_timing_wheel_top;
    import ictw_pkg::*;

    localparam int CONN_COUNT     = DEF_MAX_CONNECTIONS;
    localparam int SLOT_LIMIT     = DEF_MAX_SLOTS;
    localparam int SETTLE_CYCLES  = 80;
    localparam int RANDOM_TARGET  = 110;
    localparam int REPORT_LIMIT   = 10;
    localparam int MAX_GAP        = 6;
    localparam longint LIMIT_NS   = 64'd12 * 64'd2_000_000;

    typedef struct packed {
        t_kind             kind;
        logic [CONN_W-1:0] conn;
        logic              last;
    } t_wheel_event;

    class wheel_scoreboard;
        logic [CONN_COUNT-1:0] slot_bits [SLOT_LIMIT];
        logic [COUNT_W-1:0]    hold_count [CONN_COUNT];
        logic [CONN_COUNT-1:0] live_bits;
        int unsigned           expiring;
        int unsigned           timeout;
        int unsigned           errors;
        t_wheel_event          due[$];

        function new();
            for (int i = 0; i < SLOT_LIMIT; i++) slot_bits[i] = '0;
            for (int i = 0; i < CONN_COUNT; i++) hold_count[i] = '0;
            live_bits = '0;
            expiring  = 0;
            timeout   = 0;
            errors    = 0;
        endfunction

        function int unsigned slot_count();
            int unsigned n;
            n = timeout + 1;
            if (n > SLOT_LIMIT) n = SLOT_LIMIT;
            return n;
        endfunction

        function int unsigned outstanding();
            return due.size();
        endfunction

        function void set_timeout(int unsigned value);
            timeout = value;
            if (expiring >= slot_count()) expiring = 0;
        endfunction

        function void enter_newest(int unsigned c);
            int unsigned n, e, s;
            n = slot_count();
            e = (expiring >= n) ? 0 : expiring;
            s = (e == 0) ? n - 1 : e - 1;
            if (slot_bits[s][c]) return;
            slot_bits[s][c] = 1'b1;
            if (hold_count[c] < COUNT_MAX) hold_count[c] = hold_count[c] + 1'b1;
        endfunction

        function void expect_event(t_kind kind, logic [CONN_W-1:0] conn, logic last);
            t_wheel_event ev;
            ev.kind = kind;
            ev.conn = conn;
            ev.last = last;
            due.push_back(ev);
        endfunction

        function void note_request(t_cmd cmd, logic [CONN_W-1:0] conn);
            int unsigned n, e;
            int unsigned gone[$];
            logic        was_live;
            case (cmd)
                CMD_OPEN: begin
                    live_bits[conn] = 1'b1;
                    if (timeout != 0) enter_newest(conn);
                    expect_event(KIND_NONE, '0, 1'b1);
                end
                CMD_REFRESH: begin
                    if (timeout != 0) enter_newest(conn);
                    expect_event(KIND_NONE, '0, 1'b1);
                end
                CMD_CLOSE: begin
                    was_live = live_bits[conn];
                    live_bits[conn] = 1'b0;
                    hold_count[conn] = '0;
                    if (was_live) expect_event(KIND_CLOSED, conn, 1'b1);
                    else expect_event(KIND_NONE, '0, 1'b1);
                end
                default: begin
                    if (timeout != 0) begin
                        n = slot_count();
                        e = expiring + 1;
                        if (e >= n) e = 0;
                        expiring = e;
                        for (int i = 0; i < CONN_COUNT; i++) begin
                            if (slot_bits[e][i] && live_bits[i]) begin
                                if (hold_count[i] > 1) begin
                                    hold_count[i] = hold_count[i] - 1'b1;
                                end else begin
                                    live_bits[i] = 1'b0;
                                    hold_count[i] = '0;
                                    gone.push_back(i);
                                end
                            end
                        end
                        slot_bits[e] = '0;
                    end
                    if (gone.size() == 0) begin
                        expect_event(KIND_NONE, '0, 1'b1);
                    end else begin
                        foreach (gone[k])
                            expect_event(KIND_EXPIRED, gone[k][CONN_W-1:0], k == gone.size() - 1);
                    end
                end
            endcase
        endfunction

        function void check_event(t_kind kind, logic [CONN_W-1:0] conn, logic last);
            t_wheel_event got, want;
            got.kind = kind;
            got.conn = conn;
            got.last = last;
            if (due.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected event: kind %0d conn %0d last %0d",
                             got.kind, got.conn, got.last);
                return;
            end
            want = due.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"event mismatch: expected kind %0d conn %0d last %0d, ",
                              "got kind %0d conn %0d last %0d"},
                             want.kind, want.conn, want.last, got.kind, got.conn, got.last);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [TIMEOUT_W-1:0] i_cfg_wdata;
    bit                   gaps_on;
    int unsigned          sent;
    int unsigned          pool [8];
    wheel_scoreboard      sb;

    ictw_req_if req_ch ();
    ictw_rsp_if rsp_ch ();

    idle_connection_timing_wheel_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // entered and left at a falling edge; valid stays high for a back-to-back request
    task automatic send_request(t_cmd cmd, logic [CONN_W-1:0] conn);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.connection <= conn;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(cmd, conn);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic write_timeout(int unsigned value);
        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[TIMEOUT_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_timeout(value);
    endtask

    function automatic t_cmd pick_command();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25) return CMD_OPEN;
        if (r < 50) return CMD_REFRESH;
        if (r < 65) return CMD_CLOSE;
        return CMD_TICK;
    endfunction

    function automatic logic [CONN_W-1:0] pick_conn();
        if ($urandom_range(0, 4) == 0) return CONN_W'($urandom_range(0, CONN_COUNT - 1));
        return CONN_W'(pool[$urandom_range(0, 7)]);
    endfunction

    task automatic run_mixed(int unsigned count);
        repeat (count) send_request(pick_command(), pick_conn());
    endtask

    // open, keep the connection busy for a while, then let it age
    task automatic run_keepalive();
        logic [CONN_W-1:0] c;
        c = pick_conn();
        send_request(CMD_OPEN, c);
        repeat ($urandom_range(1, 4)) begin
            send_request(CMD_REFRESH, c);
            send_request(CMD_TICK, c);
        end
        repeat ($urandom_range(0, 3)) send_request(CMD_TICK, pick_conn());
    endtask

    // many connections at once, then a full turn of the wheel
    task automatic run_flood(bit every_conn);
        int unsigned turns;
        for (int i = 0; i < CONN_COUNT; i++)
            if (every_conn || $urandom_range(0, 2) == 0)
                send_request(($urandom_range(0, 3) == 0) ? CMD_REFRESH : CMD_OPEN, CONN_W'(i));
        turns = (sb.timeout == 0) ? 1 : sb.timeout + 1;
        repeat (turns) send_request(CMD_TICK, '0);
    endtask

    initial begin
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            int unsigned stall;
            stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            sb.check_event(t_kind'(rsp_ch.event_kind), rsp_ch.event_connection, rsp_ch.last);
            @(negedge i_clk);
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int unsigned       plan [8];
        int unsigned       phase, value, start, phase_end, pick;
        logic [CONN_W-1:0] held;
        sb                = new();
        sent              = 0;
        gaps_on           = 1'b1;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_OPEN;
        req_ch.connection = '0;
        plan = '{1, 63, 3, 0, 2, 4, 1, 7};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // keepalive off: open still marks live, refresh and tick do nothing
        write_timeout(0);
        send_request(CMD_OPEN, 6'd0);
        send_request(CMD_REFRESH, 6'd63);
        send_request(CMD_TICK, 6'd0);
        send_request(CMD_CLOSE, 6'd0);
        send_request(CMD_CLOSE, 6'd63);

        // two-slot wheel; refresh of a connection that is not live still counts
        write_timeout(1);
        send_request(CMD_OPEN, 6'd63);
        send_request(CMD_OPEN, 6'd0);
        send_request(CMD_REFRESH, 6'd63);
        send_request(CMD_REFRESH, 6'd42);
        send_request(CMD_TICK, 6'd0);

        // stale slot membership after close, reopened connection picks it up
        write_timeout(2);
        send_request(CMD_OPEN, 6'd21);
        send_request(CMD_REFRESH, 6'd21);
        send_request(CMD_TICK, 6'd0);
        send_request(CMD_REFRESH, 6'd21);
        send_request(CMD_CLOSE, 6'd21);
        send_request(CMD_OPEN, 6'd21);
        send_request(CMD_TICK, 6'd0);
        send_request(CMD_TICK, 6'd0);
        send_request(CMD_TICK, 6'd0);
        send_request(CMD_CLOSE, 6'd42);

        // retain count saturation on a connection that is not live
        write_timeout(1);
        gaps_on = ($urandom_range(0, 1) != 0);
        held = CONN_W'($urandom_range(0, CONN_COUNT - 1));
        repeat (130) begin
            send_request(CMD_REFRESH, held);
            send_request(CMD_TICK, 6'd0);
        end
        send_request(CMD_OPEN, held);
        repeat (6) send_request(CMD_TICK, 6'd0);
        send_request(CMD_CLOSE, held);

        start = sent;
        phase = 0;
        while (sent - start < RANDOM_TARGET) begin
            if (phase < 8) value = plan[phase];
            else if ($urandom_range(0, 5) == 0) value = ($urandom_range(0, 1) != 0) ? 63 : 0;
            else value = $urandom_range(1, 8);
            write_timeout(value);
            gaps_on = ($urandom_range(0, 3) != 0);
            foreach (pool[i]) pool[i] = $urandom_range(0, CONN_COUNT - 1);
            if (phase == 0) run_flood(1'b1);
            phase_end = sent + $urandom_range(12, 24);
            while (sent < phase_end) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) run_mixed($urandom_range(4, 10));
                else if (pick < 7) run_keepalive();
                else if (pick < 8 && sb.timeout <= 8) run_flood(1'b0);
                else send_request(t_cmd'($urandom_range(0, 3)),
                                  CONN_W'($urandom_range(0, CONN_COUNT - 1)));
            end
            phase++;
        end

        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
